@@ hdl/hrlc_pkg.sv @@
// Package for the HTTP request line checker: state and result types,
// status and phase codes, and the constant match patterns. No dependencies.
`default_nettype none

package hrlc_pkg;

  typedef enum logic [1:0] {
    PH_METHOD  = 2'd0,
    PH_ROUTE   = 2'd1,
    PH_VERSION = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPT      = 2'd0,
    ST_BAD_METHOD  = 2'd1,
    ST_MALFORMED   = 2'd2,
    ST_BAD_VERSION = 2'd3
  } status_t;

  localparam logic METH_GET  = 1'b0;
  localparam logic METH_POST = 1'b1;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  pos;
    logic [1:0]  meth_cand;
    logic [3:0]  route_cand;
    logic        decided;
  } state_t;

  typedef struct packed {
    logic        emit;
    status_t     status;
    logic        method_code;
    logic [1:0]  route_code;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_METHOD,
    pos:        4'd0,
    meth_cand:  2'b11,
    route_cand: 4'b1111,
    decided:    1'b0
  };

  // Method patterns: GET then POST, each including the trailing space.
  localparam logic [7:0] METH_PAT [2][5] = '{
    '{"G", "E", "T", " ", 8'h00},
    '{"P", "O", "S", "T", " "}
  };
  localparam logic [3:0] METH_LEN [2] = '{4'd4, 4'd5};
  localparam logic [3:0] METH_END [2] = '{4'd3, 4'd4};

  // Routes: exec and status are POST only, commands and operators GET only.
  localparam logic [7:0] ROUTE_PAT [4][11] = '{
    '{"/", "e", "x", "e", "c", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"/", "s", "t", "a", "t", "u", "s", " ", 8'h00, 8'h00, 8'h00},
    '{"/", "c", "o", "m", "m", "a", "n", "d", "s", " ", 8'h00},
    '{"/", "o", "p", "e", "r", "a", "t", "o", "r", "s", " "}
  };
  localparam logic [3:0] ROUTE_LEN [4] = '{4'd6, 4'd8, 4'd10, 4'd11};
  localparam logic [3:0] ROUTE_END [4] = '{4'd5, 4'd7, 4'd9, 4'd10};

  // Version string; the minor digit position is checked separately.
  localparam logic [7:0] VER_PAT [10] = '{
    "H", "T", "T", "P", "/", "1", ".", 8'h00, 8'h0D, 8'h0A
  };
  localparam logic [3:0] VER_LEN   = 4'd10;
  localparam logic [3:0] VER_MINOR = 4'd7;
  localparam logic [3:0] VER_LAST  = 4'd9;

endpackage : hrlc_pkg

`default_nettype wire

@@ hdl/hrlc_step.sv @@
// Per-byte step logic of the request line checker: next state and result.
// Purely combinational; depends on hrlc_pkg.
`default_nettype none

module hrlc_step
  import hrlc_pkg::*;
(
  input  state_t      cur,
  input  logic [7:0]  data_byte,
  input  logic        start_flag,
  output state_t      nxt,
  output result_t     res
);

  state_t     s;
  logic [1:0] mc;
  logic [3:0] rc;
  logic       found;
  logic [1:0] sel;
  logic [1:0] last_route;
  logic       need_post;

  always_comb begin
    s          = start_flag ? STATE_RESET : cur;
    nxt        = s;
    res        = '{emit: 1'b0, status: ST_ACCEPT, method_code: 1'b0, route_code: 2'd0};
    mc         = '0;
    rc         = '0;
    found      = 1'b0;
    sel        = 2'd0;
    last_route = 2'd0;
    need_post  = 1'b0;

    for (int i = 0; i < 2; i++) begin
      mc[i] = s.meth_cand[i] && (s.pos < METH_LEN[i]) &&
              (METH_PAT[i][s.pos[2:0]] == data_byte);
    end
    for (int i = 0; i < 4; i++) begin
      rc[i] = s.route_cand[i] && (s.pos < ROUTE_LEN[i]) &&
              (ROUTE_PAT[i][s.pos] == data_byte);
    end
    for (int i = 0; i < 4; i++) begin
      if (!found && rc[i] && (s.pos == ROUTE_END[i])) begin
        found = 1'b1;
        sel   = 2'(i);
      end
      if (s.route_cand[i]) begin
        last_route = 2'(i);
      end
    end

    if (!s.decided) begin
      case (s.phase)
        PH_METHOD: begin
          nxt.meth_cand = mc;
          if (mc == 2'b00) begin
            res.emit   = 1'b1;
            res.status = ST_BAD_METHOD;
          end else if (mc[0] && (s.pos == METH_END[0])) begin
            nxt.meth_cand = 2'b01;
            nxt.phase     = PH_ROUTE;
            nxt.pos       = 4'd0;
          end else if (mc[1] && (s.pos == METH_END[1])) begin
            nxt.meth_cand = 2'b10;
            nxt.phase     = PH_ROUTE;
            nxt.pos       = 4'd0;
          end else begin
            nxt.pos = s.pos + 4'd1;
          end
        end
        PH_ROUTE: begin
          nxt.route_cand = rc;
          // Routes 0 and 1 belong to POST, routes 2 and 3 to GET.
          need_post = ~sel[1];
          if (rc == 4'b0000) begin
            res.emit   = 1'b1;
            res.status = ST_MALFORMED;
          end else if (found) begin
            if (need_post != s.meth_cand[1]) begin
              res.emit   = 1'b1;
              res.status = ST_BAD_METHOD;
            end else begin
              nxt.route_cand      = '0;
              nxt.route_cand[sel] = 1'b1;
              nxt.phase           = PH_VERSION;
              nxt.pos             = 4'd0;
            end
          end else begin
            nxt.pos = s.pos + 4'd1;
          end
        end
        PH_VERSION: begin
          if (s.pos == VER_MINOR) begin
            if ((data_byte != "0") && (data_byte != "1")) begin
              res.emit   = 1'b1;
              res.status = ST_BAD_VERSION;
            end
          end else if ((s.pos >= VER_LEN) || (VER_PAT[s.pos] != data_byte)) begin
            res.emit   = 1'b1;
            res.status = ST_BAD_VERSION;
          end
          if (!res.emit) begin
            if (s.pos == VER_LAST) begin
              res.emit        = 1'b1;
              res.status      = ST_ACCEPT;
              res.method_code = s.meth_cand[1];
              res.route_code  = last_route;
            end else begin
              nxt.pos = s.pos + 4'd1;
            end
          end
        end
        default: begin
          // Unreachable phase: bytes are ignored until a start byte.
        end
      endcase
    end

    if (res.emit) begin
      nxt.decided = 1'b1;
    end
  end

endmodule : hrlc_step

`default_nettype wire

@@ hdl/http_request_line_checker.sv @@
// Top level of the HTTP request line checker: input register, state
// register and result register around hrlc_step. Depends on hrlc_pkg.
`default_nettype none

// The checker reads an HTTP request line one byte per item and gives at most
// one result per request, at the byte where the outcome is settled: accepted
// (with method and route codes), unsupported method, malformed line or
// unsupported version. The method must be "GET " or "POST ", the route one of
// "/exec " and "/status " for POST or "/commands " and "/operators " for GET,
// and the version "HTTP/1.1" or "HTTP/1.0" followed directly by CR LF. An item
// with in_start_flag set restarts the check at that byte; after a result all
// further bytes are ignored until the next start byte. Each item is held
// in an input register, passes the byte matcher into the state register,
// and any result lands in an output register, so one item is taken every
// cycle while out_stall stays low. The loop that sets this figure is the
// matcher feeding the state register. An accepted item passes the input
// register and then the result register before its result is on out_valid.
// The method and route codes are zero on any result other than accepted.

module http_request_line_checker
  import hrlc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_flag,

  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  out_status,
  output      logic        out_method_code,
  output      logic [1:0]  out_route_code
);

  // Input register.
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;

  // Checker state.
  state_t      st_r, st_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r;

  state_t      step_state;
  result_t     step_res;
  logic        advance;
  logic        in_take;
  logic        out_take;

  // The held item moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  hrlc_step u_step (
    .cur        (st_r),
    .data_byte  (s1_byte_r),
    .start_flag (s1_start_r),
    .nxt        (step_state),
    .res        (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    st_nxt = advance ? step_state : st_r;

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = step_res.emit;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_r        <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_start_flag;
    end
    if (advance && step_res.emit) begin
      res_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_method_code = res_r.method_code;
  assign out_route_code  = res_r.route_code;

  // Once a result has been given, bytes without a start flag give no result.
  a_quiet_after_result : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !s1_start_r && st_r.decided) |=> !out_valid_r)
    else $error("result produced after the request was already decided");

  // Every result marks the request as decided.
  a_decided_after_emit : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_res.emit) |=> st_r.decided)
    else $error("decided flag not set after a result");

  // Rejections carry zero codes.
  a_zero_codes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.status != ST_ACCEPT)) |->
      ((res_r.method_code == 1'b0) && (res_r.route_code == 2'd0)))
    else $error("non-zero codes on a rejected request");

  // An accepted request pairs GET with commands or operators, POST with the rest.
  a_route_method : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.status == ST_ACCEPT)) |->
      (res_r.method_code != res_r.route_code[1]))
    else $error("accepted route does not belong to the accepted method");

endmodule : http_request_line_checker

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for http_request_line_checker: byte-wise request
// lines in, verdicts out. Depends on hrlc_pkg and the checker itself.
`timescale 1ns / 1ps

module tb;
  import hrlc_pkg::*;

  // One verdict as it leaves the checker.
  typedef struct packed {
    logic [1:0] status;
    logic       method;
    logic [1:0] route;
  } verdict_t;

  // Tracks the request line byte by byte, keeps the verdicts still owed by the
  // checker in arrival order, and compares each verdict that comes out.
  class line_scoreboard;
    verdict_t   due_verdicts[$];
    int         failures;
    string      meth_txt[2];
    string      route_txt[4];
    string      ver_txt;
    phase_t     phase;
    logic [3:0] pos;
    logic [1:0] meth_cand;
    logic [3:0] route_cand;
    logic       decided;

    function new();
      meth_txt  = '{"GET ", "POST "};
      route_txt = '{"/exec ", "/status ", "/commands ", "/operators "};
      // The minor digit at index 7 is checked on its own.
      ver_txt   = "HTTP/1.x\r\n";
      failures  = 0;
      restart();
    endfunction

    function void restart();
      phase      = PH_METHOD;
      pos        = 4'd0;
      meth_cand  = 2'b11;
      route_cand = 4'b1111;
      decided    = 1'b0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void decide(logic [1:0] status, logic method, logic [1:0] route);
      verdict_t v;
      v.status = status;
      v.method = method;
      v.route  = route;
      due_verdicts.push_back(v);
      decided = 1'b1;
    endfunction

    function void take_byte(logic [7:0] b, logic start);
      string pat;
      logic  is_post;
      logic  need_post;
      int    last;
      if (start) restart();
      if (decided) return;
      case (phase)
        PH_METHOD: begin
          for (int i = 0; i < 2; i++) begin
            pat = meth_txt[i];
            if (meth_cand[i] && (int'(pos) >= pat.len() || pat[pos] != b))
              meth_cand[i] = 1'b0;
          end
          if (meth_cand == 2'b00) begin
            decide(ST_BAD_METHOD, 1'b0, 2'd0);
            return;
          end
          for (int i = 0; i < 2; i++) begin
            pat = meth_txt[i];
            if (meth_cand[i] && int'(pos) + 1 == pat.len()) begin
              meth_cand = 2'b01 << i;
              phase     = PH_ROUTE;
              pos       = 4'd0;
              return;
            end
          end
          pos++;
        end
        PH_ROUTE: begin
          for (int i = 0; i < 4; i++) begin
            pat = route_txt[i];
            if (route_cand[i] && (int'(pos) >= pat.len() || pat[pos] != b))
              route_cand[i] = 1'b0;
          end
          if (route_cand == 4'b0000) begin
            decide(ST_MALFORMED, 1'b0, 2'd0);
            return;
          end
          for (int i = 0; i < 4; i++) begin
            pat = route_txt[i];
            if (route_cand[i] && int'(pos) + 1 == pat.len()) begin
              // exec and status belong to POST, the other two to GET.
              need_post = (i < 2);
              is_post   = meth_cand[1];
              if (need_post != is_post) begin
                decide(ST_BAD_METHOD, 1'b0, 2'd0);
                return;
              end
              route_cand = 4'b0001 << i;
              phase      = PH_VERSION;
              pos        = 4'd0;
              return;
            end
          end
          pos++;
        end
        PH_VERSION: begin
          if (pos == 4'd7) begin
            if (b != "0" && b != "1") begin
              decide(ST_BAD_VERSION, 1'b0, 2'd0);
              return;
            end
          end else if (pos >= 4'd10 || ver_txt[pos] != b) begin
            decide(ST_BAD_VERSION, 1'b0, 2'd0);
            return;
          end
          if (pos == 4'd9) begin
            last = 0;
            for (int i = 0; i < 4; i++)
              if (route_cand[i]) last = i;
            decide(ST_ACCEPT, meth_cand[1], 2'(last));
            return;
          end
          pos++;
        end
        default: ;
      endcase
    endfunction

    function void match_verdict(logic [1:0] status, logic method, logic [1:0] route);
      verdict_t want;
      if (due_verdicts.size() == 0) begin
        flag($sformatf("unexpected verdict: status %0d method %0d route %0d",
                       status, method, route));
        return;
      end
      want = due_verdicts.pop_front();
      if (want.status !== status || want.method !== method || want.route !== route)
        flag($sformatf({"verdict differs: expected status %0d method %0d route %0d,",
                        " got status %0d method %0d route %0d"},
                       want.status, want.method, want.route, status, method, route));
    endfunction

    function void check_drained();
      if (due_verdicts.size() != 0)
        flag($sformatf("%0d verdicts never arrived", due_verdicts.size()));
    endfunction
  endclass

  localparam int QUIET_LIMIT = 1000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_start_flag;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_status;
  logic       out_method_code;
  logic [1:0] out_route_code;

  line_scoreboard sb = new();

  // Bytes of the request line about to be sent.
  logic [7:0] line_buf[$];
  int         items_sent;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         quiet_cycles;

  // Characters that turn up in the patterns, so that corrupted lines stay
  // close to the real thing and get well into the route and version checks.
  string      hint_chars = "GETPOS /excstaumndrHTP1.0\r\n";

  http_request_line_checker uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_start_flag   (in_start_flag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_method_code (out_method_code),
    .out_route_code  (out_route_code)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The receiver holds off at random, its rate set per stage of the run.
  initial out_stall = 1'b0;
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Handshakes are sampled at the rising edge. The output side is checked
  // first: a verdict leaving at this edge can never belong to the byte that
  // is taken at the same edge. The watchdog ends the run when nothing at all
  // has moved for too long.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.match_verdict(out_status, out_method_code, out_route_code);
    if (rst_n && in_valid && !in_stall)
      sb.take_byte(in_data_byte, in_start_flag);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("http_request_line_checker: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item at the falling edge, after an optional random gap, and
  // returns at the falling edge that follows its acceptance.
  task automatic send_item(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_data_byte  = b;
    in_start_flag = start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic void load_text(string s);
    for (int i = 0; i < s.len(); i++)
      line_buf.push_back(s[i]);
  endfunction

  // Sends the buffered line. The first byte carries the start flag if asked;
  // now and then a stray start flag lands in the middle of a line as well.
  task automatic send_line(input logic with_start);
    logic start;
    for (int i = 0; i < line_buf.size(); i++) begin
      start = (i == 0) ? with_start : ($urandom_range(199) == 0);
      send_item(line_buf[i], start);
    end
    line_buf.delete();
  endtask

  function automatic logic [7:0] hint_byte();
    return hint_chars[$urandom_range(hint_chars.len() - 1)];
  endfunction

  // Builds one random line. Most are complete requests, either valid or with
  // the route belonging to the other method; many of those then get a single
  // byte replaced, dropped, inserted or the tail cut off. The rest is noise.
  function automatic void build_random_line();
    int  kind;
    int  meth;
    int  route;
    int  at;
    int  len;
    kind = $urandom_range(99);
    meth = $urandom_range(1);
    if (kind < 85) begin
      // POST goes with exec or status, GET with commands or operators.
      route = (meth == 1) ? $urandom_range(1) : 2 + $urandom_range(1);
      if (kind >= 40 && kind < 55) route = route ^ 2;
      load_text(sb.meth_txt[meth]);
      load_text(sb.route_txt[route]);
      load_text($urandom_range(1) ? "HTTP/1.1\r\n" : "HTTP/1.0\r\n");
      if (kind >= 55) begin
        at = $urandom_range(line_buf.size() - 1);
        case ($urandom_range(4))
          0: line_buf[at] = 8'($urandom_range(255));
          1: line_buf[at] = hint_byte();
          2: line_buf.delete(at);
          3: while (line_buf.size() > at) void'(line_buf.pop_back());
          default: line_buf.insert(at, hint_byte());
        endcase
      end
    end else begin
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++)
        line_buf.push_back($urandom_range(1) ? hint_byte() : 8'($urandom_range(255)));
    end
    // Trailing bytes: ignored after a verdict, still matched otherwise.
    len = $urandom_range(2);
    for (int i = 0; i < len; i++)
      line_buf.push_back(8'($urandom_range(255)));
  endfunction

  task automatic run_directed();
    // Before any start byte the checker is already at byte 0 of a request.
    load_text("GET /commands HTTP/1.1\r\n");
    send_line(1'b0);
    load_text("POST /exec HTTP/1.0\r\n");
    send_line(1'b1);
    load_text("POST /status HTTP/1.1\r\n");
    send_line(1'b1);
    // Bytes after a verdict are ignored until the next start byte.
    load_text("GET /operators HTTP/1.0\r\nxyz");
    send_line(1'b1);
    // Routes that belong to the other method, reported at the closing space.
    load_text("GET /exec ");
    send_line(1'b1);
    load_text("POST /operators ");
    send_line(1'b1);
    // Method failures, including a zero byte straight away.
    load_text("PUT");
    send_line(1'b1);
    load_text("GETX");
    send_line(1'b1);
    line_buf.push_back(8'h00);
    send_line(1'b1);
    // Malformed routes, one of them with an all-ones byte.
    load_text("GET /cmd");
    send_line(1'b1);
    load_text("GET ");
    line_buf.push_back(8'hFF);
    send_line(1'b1);
    // A new start byte in the middle of a line restarts the check.
    load_text("GET /com");
    send_line(1'b1);
    load_text("POST /status HTTP/1.0\r\n");
    send_line(1'b1);
    // Version failures: major digit, minor digit, and no LF after CR.
    load_text("POST /status HTTP/2.0");
    send_line(1'b1);
    load_text("GET /commands HTTP/1.5");
    send_line(1'b1);
    load_text("POST /exec HTTP/1.1\r\r");
    send_line(1'b1);
  endtask

  initial begin
    int send_pct[3];
    int recv_pct[3];
    int goal;
    int lines;
    send_pct = '{11, 62, 0};
    recv_pct = '{62, 11, 0};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_start_flag  = 1'b0;
    items_sent     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = send_pct[0];
    recv_stall_pct = recv_pct[0];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    // Three stages of random lines: a slow receiver, then a slow sender, then
    // both at full rate.
    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct  = send_pct[stage];
      recv_stall_pct = recv_pct[stage];
      goal  = items_sent + 85;
      lines = 0;
      while (items_sent < goal || lines < 3) begin
        build_random_line();
        send_line($urandom_range(9) != 0);
        lines++;
      end
    end
    in_valid = 1'b0;

    // Let every owed verdict come out, then leave room for stragglers.
    while (sb.due_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.check_drained();
    if (sb.failures == 0)
      $display("http_request_line_checker: match");
    else
      $display("http_request_line_checker: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/hrlc_pkg.sv
hdl/hrlc_step.sv
hdl/http_request_line_checker.sv
test/tb.sv
